@@ design/sspan_pkg.sv @@
// Shared constants for the sentence span segmenter: byte codes, field widths
// and reset defaults. No dependencies.
package sspan_pkg;

    localparam int MAX_TEXT_BYTES_DEF = 65536;

    localparam int CAP_W    = 13;
    localparam int BEGIN_W  = 16;
    localparam int END_W    = 17;
    localparam int NUMBER_W = 12;

    localparam logic [CAP_W-1:0] SPAN_CAP_RESET = 13'd256;

    localparam logic [7:0] CHAR_PERIOD   = 8'h2E;
    localparam logic [7:0] CHAR_BANG     = 8'h21;
    localparam logic [7:0] CHAR_QUESTION = 8'h3F;
    localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;

endpackage

@@ design/sentence_span_segmenter.sv @@
// Sentence span segmenter top level: byte stream in, trimmed sentence spans out.
// Depends on sspan_pkg for byte codes, widths and reset defaults.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one text byte per request,
//   with last_byte set on the final byte of a text. The output channel
//   (out_valid/out_ready) delivers one span request for each non-empty
//   sentence: span_begin, span_end, sentence_number and at_text_end.
//   The config channel (cfg_valid/cfg_ready/cfg_data) writes the span cap;
//   cfg_ready is always high. Write it only while the block is idle.
//   Throughput: one byte per cycle while in_ready is high. All per-byte work
//   is a few compares and register updates in the cycle the byte is accepted;
//   a finished span is then registered into the output or skid register.
//   The output side has a result register plus one skid register, so a byte
//   is still taken while one finished span waits. in_ready drops only when
//   both are full, and returns the cycle after the receiver takes a span.
//   Reset clears all text state, empties the output buffer and sets
//   the span cap to 256.
module sentence_span_segmenter #(
    parameter int MAX_TEXT_BYTES = sspan_pkg::MAX_TEXT_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     text_byte,
    input  logic                           last_byte,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sspan_pkg::BEGIN_W-1:0]  span_begin,
    output logic [sspan_pkg::END_W-1:0]    span_end,
    output logic [sspan_pkg::NUMBER_W-1:0] sentence_number,
    output logic                           at_text_end,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sspan_pkg::CAP_W-1:0]    cfg_data
);

    localparam int OFF_W = $clog2(MAX_TEXT_BYTES + 1);
    localparam int IDX_W = $clog2(MAX_TEXT_BYTES);
    localparam int EXT_W = IDX_W + sspan_pkg::END_W;
    localparam logic [OFF_W-1:0] OFF_LIMIT = OFF_W'(MAX_TEXT_BYTES);

    typedef struct packed {
        logic [sspan_pkg::BEGIN_W-1:0]  span_begin;
        logic [sspan_pkg::END_W-1:0]    span_end;
        logic [sspan_pkg::NUMBER_W-1:0] number;
        logic                           at_end;
    } result_t;

    logic [sspan_pkg::CAP_W-1:0] span_cap_reg;

    logic [OFF_W-1:0]            byte_offset_reg, byte_offset_next;
    logic                        has_content_reg, has_content_next;
    logic [IDX_W-1:0]            first_reg, first_next;
    logic [IDX_W-1:0]            last_reg, last_next;
    logic                        term_run_reg, term_run_next;
    logic                        nl_pending_reg, nl_pending_next;
    logic [sspan_pkg::CAP_W-1:0] spans_reg, spans_next;
    logic [IDX_W-1:0]            bound_first, bound_last;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;
    result_t result_new;
    logic    emit;

    logic in_fire, out_fire;
    logic in_range, active, is_term, is_newline, is_content, close_span;
    logic [EXT_W-1:0] begin_wide, end_wide;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    assign in_range   = byte_offset_reg < OFF_LIMIT;
    assign active     = in_range && (spans_reg < span_cap_reg);
    assign is_term    = (text_byte == sspan_pkg::CHAR_PERIOD) ||
                        (text_byte == sspan_pkg::CHAR_BANG) ||
                        (text_byte == sspan_pkg::CHAR_QUESTION);
    assign is_newline = text_byte == sspan_pkg::CHAR_NEWLINE;
    assign is_content = text_byte > sspan_pkg::CHAR_SPACE;

    always_comb
    begin
        byte_offset_next = byte_offset_reg;
        has_content_next = has_content_reg;
        first_next       = first_reg;
        last_next        = last_reg;
        term_run_next    = term_run_reg;
        nl_pending_next  = nl_pending_reg;
        spans_next       = spans_reg;
        close_span       = 1'b0;
        emit             = 1'b0;

        if (active)
        begin
            if (is_term)
            begin
                nl_pending_next = 1'b0;
                close_span      = !term_run_reg;
                term_run_next   = 1'b1;
            end
            else
            begin
                term_run_next = 1'b0;
                if (is_newline)
                begin
                    close_span      = nl_pending_reg;
                    nl_pending_next = !nl_pending_reg;
                end
                else
                begin
                    nl_pending_next = 1'b0;
                    if (is_content)
                    begin
                        if (!has_content_reg)
                        begin
                            first_next = byte_offset_reg[IDX_W-1:0];
                        end
                        last_next        = byte_offset_reg[IDX_W-1:0];
                        has_content_next = 1'b1;
                    end
                end
            end
        end

        // Hold the bounds as this byte leaves them, ahead of the final-byte clear.
        bound_first = first_next;
        bound_last  = last_next;

        if (close_span)
        begin
            emit             = has_content_reg;
            has_content_next = 1'b0;
        end

        // Flush the tail on the final byte unless a span closed already.
        if (last_byte && !emit && (spans_reg < span_cap_reg) && has_content_next)
        begin
            emit = 1'b1;
        end

        if (emit)
        begin
            spans_next = spans_reg + 1'b1;
        end

        if (in_range)
        begin
            byte_offset_next = byte_offset_reg + 1'b1;
        end

        if (last_byte)
        begin
            byte_offset_next = '0;
            has_content_next = 1'b0;
            first_next       = '0;
            last_next        = '0;
            term_run_next    = 1'b0;
            nl_pending_next  = 1'b0;
            spans_next       = '0;
        end
    end

    // Close paths never touch the bounds, so the updated bounds serve both cases.
    assign begin_wide = EXT_W'(bound_first);
    assign end_wide   = EXT_W'(bound_last) + EXT_W'(1);

    always_comb
    begin
        result_new.span_begin = begin_wide[sspan_pkg::BEGIN_W-1:0];
        result_new.span_end   = end_wide[sspan_pkg::END_W-1:0];
        result_new.number     = spans_reg[sspan_pkg::NUMBER_W-1:0];
        result_new.at_end     = last_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_cap_reg    <= sspan_pkg::SPAN_CAP_RESET;
            byte_offset_reg <= '0;
            has_content_reg <= 1'b0;
            first_reg       <= '0;
            last_reg        <= '0;
            term_run_reg    <= 1'b0;
            nl_pending_reg  <= 1'b0;
            spans_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                span_cap_reg <= cfg_data;
            end
            if (in_fire)
            begin
                byte_offset_reg <= byte_offset_next;
                has_content_reg <= has_content_next;
                first_reg       <= first_next;
                last_reg        <= last_next;
                term_run_reg    <= term_run_next;
                nl_pending_reg  <= nl_pending_next;
                spans_reg       <= spans_next;
            end
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_fire)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_fire && emit)
            begin
                if (out_valid_reg && !out_ready)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_fire && emit)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_reg <= result_new;
            end
            else
            begin
                out_reg <= result_new;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign span_begin      = out_reg.span_begin;
    assign span_end        = out_reg.span_end;
    assign sentence_number = out_reg.number;
    assign at_text_end     = out_reg.at_end;

endmodule

@@ verif/sentence_span_checker.sv @@
`timescale 1ns / 100ps
// Span checker for the sentence span segmenter: watches the byte, span and cap
// channels, predicts the spans and compares them. Depends on sspan_pkg.
module sentence_span_checker #(
    parameter int MAX_TEXT_BYTES = sspan_pkg::MAX_TEXT_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [7:0]                     text_byte,
    input  logic                           last_byte,

    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [sspan_pkg::BEGIN_W-1:0]  span_begin,
    input  logic [sspan_pkg::END_W-1:0]    span_end,
    input  logic [sspan_pkg::NUMBER_W-1:0] sentence_number,
    input  logic                           at_text_end,

    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [sspan_pkg::CAP_W-1:0]    cfg_data,

    output int                             open_spans,
    output int                             mismatches
);

    typedef struct packed {
        logic [sspan_pkg::BEGIN_W-1:0]  first_off;
        logic [sspan_pkg::END_W-1:0]    end_off;
        logic [sspan_pkg::NUMBER_W-1:0] number;
        logic                           at_end;
    } span_t;

    span_t expected_spans[$];

    logic [sspan_pkg::CAP_W-1:0] sentence_cap;
    logic [31:0]                 text_offset;
    logic [31:0]                 span_first;
    logic [31:0]                 span_last;
    logic [sspan_pkg::CAP_W-1:0] span_count;
    bit                          span_open;
    bit                          in_stop_run;
    bit                          lone_newline;
    int                          errs;

    function automatic void clear_text();
        text_offset  = '0;
        span_first   = '0;
        span_last    = '0;
        span_count   = '0;
        span_open    = 1'b0;
        in_stop_run  = 1'b0;
        lone_newline = 1'b0;
    endfunction

    // Queue the current sentence if it holds content; returns 1 if it did.
    function automatic bit close_span(input bit fin);
        span_t s;
        bit    made;
        made = 1'b0;
        if (span_open) begin
            s.first_off = span_first[sspan_pkg::BEGIN_W-1:0];
            s.end_off   = span_last[sspan_pkg::END_W-1:0] + 1'b1;
            s.number    = span_count[sspan_pkg::NUMBER_W-1:0];
            s.at_end    = fin;
            expected_spans = {expected_spans, s};
            span_count = span_count + 1'b1;
            made = 1'b1;
        end
        span_open = 1'b0;
        return made;
    endfunction

    function automatic void segment_byte(input logic [7:0] b, input bit fin);
        bit made;
        made = 1'b0;
        if (text_offset < MAX_TEXT_BYTES && span_count < sentence_cap) begin
            if (b == sspan_pkg::CHAR_PERIOD || b == sspan_pkg::CHAR_BANG ||
                b == sspan_pkg::CHAR_QUESTION) begin
                lone_newline = 1'b0;
                // only the first stop of a run closes the sentence
                if (!in_stop_run)
                    made = close_span(fin);
                in_stop_run = 1'b1;
            end else begin
                in_stop_run = 1'b0;
                if (b == sspan_pkg::CHAR_NEWLINE) begin
                    if (lone_newline) begin
                        lone_newline = 1'b0;
                        made = close_span(fin);
                    end else begin
                        lone_newline = 1'b1;
                    end
                end else begin
                    lone_newline = 1'b0;
                    if (b > sspan_pkg::CHAR_SPACE) begin
                        if (!span_open)
                            span_first = text_offset;
                        span_last = text_offset;
                        span_open = 1'b1;
                    end
                end
            end
        end
        if (text_offset < MAX_TEXT_BYTES)
            text_offset = text_offset + 1;
        if (fin) begin
            if (!made && span_count < sentence_cap)
                made = close_span(1'b1);
            clear_text();
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        span_t want;
        if (!rst_n) begin
            sentence_cap = sspan_pkg::SPAN_CAP_RESET;
            clear_text();
            expected_spans.delete();
            errs = 0;
            open_spans <= 0;
            mismatches <= 0;
        end else begin
            // retire first: a span taken now comes from an earlier byte
            if (out_valid && out_ready) begin
                if (expected_spans.size() == 0) begin
                    $error("unexpected span: begin %0d end %0d number %0d at_text_end %0d",
                           span_begin, span_end, sentence_number, at_text_end);
                    errs++;
                end else begin
                    want = expected_spans.pop_front();
                    if (span_begin !== want.first_off) begin
                        $error("span_begin: expected %0d, actual %0d",
                               want.first_off, span_begin);
                        errs++;
                    end
                    if (span_end !== want.end_off) begin
                        $error("span_end: expected %0d, actual %0d", want.end_off, span_end);
                        errs++;
                    end
                    if (sentence_number !== want.number) begin
                        $error("sentence_number: expected %0d, actual %0d",
                               want.number, sentence_number);
                        errs++;
                    end
                    if (at_text_end !== want.at_end) begin
                        $error("at_text_end: expected %0d, actual %0d",
                               want.at_end, at_text_end);
                        errs++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                sentence_cap = cfg_data;
            if (in_valid && in_ready)
                segment_byte(text_byte, last_byte);
            open_spans <= expected_spans.size();
            mismatches <= errs;
        end
    end

endmodule

@@ verif/sentence_span_segmenter_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the sentence span segmenter: clock, reset, byte and cap
// stimulus, span receiver and verdict. Depends on sspan_pkg and the span checker.
module sentence_span_segmenter_tb;

    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int PHASE_BYTES = 130;

    logic                           clk             = 1'b0;
    logic                           rst_n           = 1'b0;
    logic                           in_valid        = 1'b0;
    logic                           in_ready;
    logic [7:0]                     text_byte       = '0;
    logic                           last_byte       = 1'b0;
    logic                           out_valid;
    logic                           out_ready       = 1'b0;
    logic [sspan_pkg::BEGIN_W-1:0]  span_begin;
    logic [sspan_pkg::END_W-1:0]    span_end;
    logic [sspan_pkg::NUMBER_W-1:0] sentence_number;
    logic                           at_text_end;
    logic                           cfg_valid       = 1'b0;
    logic                           cfg_ready;
    logic [sspan_pkg::CAP_W-1:0]    cfg_data        = '0;

    int   open_spans;
    int   fail_count;
    int   cycle_count   = 0;
    int   bytes_sent    = 0;
    int   hold_left     = 0;
    bit   gap_on        = 1'b0;
    bit   stall_on      = 1'b0;
    bit   long_hold_req = 1'b0;

    logic [7:0] text_buf[$];

    sentence_span_segmenter DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .text_byte       (text_byte),
        .last_byte       (last_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .span_begin      (span_begin),
        .span_end        (span_end),
        .sentence_number (sentence_number),
        .at_text_end     (at_text_end),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    sentence_span_checker span_checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .text_byte       (text_byte),
        .last_byte       (last_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .span_begin      (span_begin),
        .span_end        (span_end),
        .sentence_number (sentence_number),
        .at_text_end     (at_text_end),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .open_spans      (open_spans),
        .mismatches      (fail_count)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sentence_span_segmenter test failed");
            $finish;
        end
    end

    // Span receiver: random stall bursts, plus one long hold on request.
    initial begin
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = 300;
                out_ready <= 1'b0;
            end else if (stall_on && $urandom_range(0, 9) == 0) begin
                hold_left = $urandom_range(1, 11) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (gap_on && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    // Send the buffered bytes; flag the final one only when the text closes here.
    task automatic flush_text(input bit close_text);
        int i;
        for (i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], close_text && (i == text_buf.size() - 1));
        text_buf.delete();
    endtask

    function automatic void add_byte(input logic [7:0] b);
        text_buf = {text_buf, b};
    endfunction

    task automatic add_string(input string s);
        foreach (s[i]) add_byte(s[i]);
    endtask

    // Hold the byte stream until every span is out, then write the cap.
    task automatic write_cap(input logic [sspan_pkg::CAP_W-1:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (open_spans == 0);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] word_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 8'($urandom_range(8'h61, 8'h7A));
        else if (r < 85)
            return 8'($urandom_range(8'h30, 8'h5A));
        else
            return 8'($urandom_range(8'h80, 8'hFF));
    endfunction

    function automatic logic [7:0] blank_byte();
        if ($urandom_range(0, 1))
            return sspan_pkg::CHAR_SPACE;
        return 8'($urandom_range(0, 8'h20));
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom_range(0, 255));
            3:       return sspan_pkg::CHAR_PERIOD;
            4:       return sspan_pkg::CHAR_BANG;
            5:       return sspan_pkg::CHAR_QUESTION;
            6:       return sspan_pkg::CHAR_NEWLINE;
            7:       return sspan_pkg::CHAR_SPACE;
            default: return word_byte();
        endcase
    endfunction

    task automatic build_text(input bit noisy);
        int n_sent;
        int r;
        if (noisy) begin
            repeat ($urandom_range(1, 40)) add_byte(noise_byte());
        end else begin
            n_sent = $urandom_range(1, 6);
            repeat (n_sent) begin
                repeat ($urandom_range(0, 2)) add_byte(blank_byte());
                // zero words leaves an empty sentence
                repeat ($urandom_range(0, 4)) begin
                    repeat ($urandom_range(1, 6)) add_byte(word_byte());
                    if ($urandom_range(0, 3) != 0)
                        add_byte(blank_byte());
                end
                r = $urandom_range(0, 9);
                if (r < 5) begin
                    repeat ($urandom_range(1, 3))
                        case ($urandom_range(0, 2))
                            0:       add_byte(sspan_pkg::CHAR_PERIOD);
                            1:       add_byte(sspan_pkg::CHAR_BANG);
                            default: add_byte(sspan_pkg::CHAR_QUESTION);
                        endcase
                end else if (r < 7) begin
                    repeat (2) add_byte(sspan_pkg::CHAR_NEWLINE);
                end else if (r == 7) begin
                    repeat (3) add_byte(sspan_pkg::CHAR_NEWLINE);
                end else if (r == 8) begin
                    add_byte(sspan_pkg::CHAR_NEWLINE);
                end
            end
        end
    endtask

    initial begin
        logic [sspan_pkg::CAP_W-1:0] cap_list [8];
        int                          off;
        int                          p;
        int                          phase_start;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed texts at the reset cap
        add_string("  Hi . ");
        flush_text(1'b1);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_string("!!?x");
        flush_text(1'b1);
        add_string("a.b?");
        flush_text(1'b1);
        add_string("x\n\ny\n\n\nz");
        flush_text(1'b1);
        add_string(" \t.\n\n ");
        flush_text(1'b1);

        // cap reached: the rest of the text is dropped
        write_cap(13'd1);
        add_string("a.b.c");
        flush_text(1'b1);

        // cap changed between two halves of one text
        write_cap(sspan_pkg::SPAN_CAP_RESET);
        add_string("ab c");
        flush_text(1'b0);
        write_cap(13'd2);
        add_string("d.e.f.g");
        flush_text(1'b1);

        write_cap(13'd0);
        add_string("a.b");
        flush_text(1'b1);

        // many sentences in one text at the widest cap
        write_cap('1);
        for (off = 0; off < 30; off++) begin
            send_byte(8'h61, 1'b0);
            send_byte(sspan_pkg::CHAR_PERIOD, off == 29);
        end

        cap_list[0] = sspan_pkg::SPAN_CAP_RESET;
        cap_list[1] = 13'd3;
        cap_list[2] = 13'd1;
        cap_list[3] = 13'd4096;
        cap_list[4] = 13'd0;
        cap_list[5] = 13'($urandom_range(1, 8191));
        cap_list[6] = 13'd2;
        cap_list[7] = '1;

        gap_on   = 1'b1;
        stall_on = 1'b1;
        for (p = 0; p < 8; p++) begin
            write_cap(cap_list[p]);
            if (p == 0) begin
                // fill the output buffer while the receiver holds off
                long_hold_req = 1'b1;
                repeat (40) begin
                    add_string("a.");
                    flush_text(1'b1);
                end
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                build_text($urandom_range(0, 4) == 0);
                flush_text(1'b1);
            end
        end

        gap_on   = 1'b0;
        stall_on = 1'b0;
        write_cap(13'($urandom_range(1, 8191)));
        phase_start = bytes_sent;
        while (bytes_sent - phase_start < 150) begin
            build_text($urandom_range(0, 4) == 0);
            flush_text(1'b1);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (open_spans == 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && open_spans == 0)
            $display("sentence_span_segmenter test passed");
        else
            $display("sentence_span_segmenter test failed");
        $finish;
    end

endmodule

@@ files.f @@
design/sspan_pkg.sv
design/sentence_span_segmenter.sv
verif/sentence_span_checker.sv
verif/sentence_span_segmenter_tb.sv
